>>> design/pal_pkg.sv
// Package for the positional array list: operation codes, status codes and cell control.
package pal_pkg;

	localparam int FUNC_W   = 3;
	localparam int POS_W    = 7;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 8;

	localparam logic [FUNC_W-1:0] OP_INSERT  = 3'd0;
	localparam logic [FUNC_W-1:0] OP_DELETE  = 3'd1;
	localparam logic [FUNC_W-1:0] OP_READ    = 3'd2;
	localparam logic [FUNC_W-1:0] OP_REPLACE = 3'd3;
	localparam logic [FUNC_W-1:0] OP_CLEAR   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	// Broadcast to every cell; at most one bit is set, and only on a successful beat.
	typedef struct packed {
		logic ins;
		logic del;
		logic rep;
	} pal_cell_ctrl_t;

endpackage

>>> design/pal_if.sv
// Valid/ready channel interfaces for the request and response beats.
interface pal_req_if;
	logic                               valid;
	logic                               ready;
	logic [pal_pkg::FUNC_W-1:0]         func;
	logic [pal_pkg::POS_W-1:0]          position;
	logic signed [pal_pkg::WORD_W-1:0]  value;

	modport source (output valid, output func, output position, output value, input ready);
	modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface pal_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [pal_pkg::WORD_W-1:0]  data;
	logic [pal_pkg::STATUS_W-1:0]       status;
	logic [pal_pkg::LEN_W-1:0]          length;

	modport source (output valid, output data, output status, output length, input ready);
	modport sink   (input valid, input data, input status, input length, output ready);
endinterface

>>> design/pal_cell.sv
// One storage cell of the list: holds one entry and trades it with its neighbors.
module pal_cell #(
	parameter int INDEX = 0,
	parameter int CMP_W = 8
) (
	input  logic                                clk,
	input  pal_pkg::pal_cell_ctrl_t             ctrl,
	input  logic [CMP_W-1:0]                    pos,
	input  logic signed [pal_pkg::WORD_W-1:0]   value,
	input  logic signed [pal_pkg::WORD_W-1:0]   left,
	input  logic signed [pal_pkg::WORD_W-1:0]   right,
	output logic signed [pal_pkg::WORD_W-1:0]   entry,
	output logic signed [pal_pkg::WORD_W-1:0]   tap
);
	import pal_pkg::*;

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

	logic                       hit;
	logic                       above;
	logic signed [WORD_W-1:0]   entry_q;

	assign hit   = (pos == MY_IDX);
	assign above = (MY_IDX > pos);

	// Payload only; an entry is meaningful once the count covers it.
	always_ff @(posedge clk) begin
		if (ctrl.ins && above) begin
			entry_q <= left;
		end else if ((ctrl.ins || ctrl.rep) && hit) begin
			entry_q <= value;
		end else if (ctrl.del && (above || hit)) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;
	assign tap   = hit ? entry_q : '0;

endmodule

>>> design/positional_array_list.sv
// Top level of the positional array list: a row of entry cells with a count and result register.
// The result is registered and appears in the cycle after its request beat is accepted.
// Throughput: one operation per cycle, insert and delete included, since every cell
// shifts at once; the request side stalls only while a held result is not taken.
// Reset: arst_n clears the count and the result valid flag at once; entry cells are not
// reset, and no clearing pass is needed because only entries below the count are read.
module positional_array_list #(
	parameter int CAPACITY = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	pal_req_if.sink    req,
	pal_rsp_if.source  rsp
);
	import pal_pkg::*;

	// The count must hold CAPACITY itself; compares are done wide enough for both
	// the count and the seven bit position.
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_nxt;
	logic                      rsp_valid_q;
	logic signed [WORD_W-1:0]  data_q;
	logic [STATUS_W-1:0]       status_q;
	logic [LEN_W-1:0]          length_q;

	logic                      accept;
	logic [CMP_W-1:0]          pos_x;
	logic [CMP_W-1:0]          cnt_x;
	logic                      full;
	logic                      empty;
	logic signed [WORD_W-1:0]  rd_word;
	logic signed [WORD_W-1:0]  data_nxt;
	logic [STATUS_W-1:0]       status_nxt;
	pal_cell_ctrl_t            ctrl_raw;
	pal_cell_ctrl_t            ctrl;

	logic signed [WORD_W-1:0]  entry_w [CAPACITY];
	logic signed [WORD_W-1:0]  tap_w   [CAPACITY];

	// The result register parts the two sides: a new beat is taken whenever the
	// held result is gone or is being taken in this same cycle.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign pos_x = CMP_W'(req.position);
	assign cnt_x = CMP_W'(count_q);
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// Each cell presents its entry only when it is the addressed one, so the read
	// port is an OR over all cell taps.
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_word = rd_word | tap_w[i];
		end
	end

	// Decode the operation, check it against the count, and decide what the cells do.
	// A failed check leaves the cells and the count untouched.
	always_comb begin
		ctrl_raw   = '0;
		status_nxt = ST_OK;
		data_nxt   = '0;
		count_nxt  = count_q;
		case (req.func)
			OP_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else if (pos_x > cnt_x) begin
					status_nxt = ST_RANGE;
				end else begin
					ctrl_raw.ins = 1'b1;
					count_nxt    = count_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					status_nxt = ST_RANGE;
				end else begin
					ctrl_raw.del = 1'b1;
					data_nxt     = rd_word;
					count_nxt    = count_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (pos_x >= cnt_x) begin
					status_nxt = ST_RANGE;
				end else begin
					data_nxt = rd_word;
				end
			end
			OP_REPLACE: begin
				if (pos_x >= cnt_x) begin
					status_nxt = ST_RANGE;
				end else begin
					ctrl_raw.rep = 1'b1;
				end
			end
			OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				// Unused codes do nothing and report success.
			end
		endcase
	end

	assign ctrl = accept ? ctrl_raw : '0;

	// The row of cells. Insert pulls each entry from its lower neighbor, delete from
	// its upper neighbor; the ends see zero, which only lands in unused cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [WORD_W-1:0] left_w;
		logic signed [WORD_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end

		pal_cell #(
			.INDEX (i),
			.CMP_W (CMP_W)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.pos   (pos_x),
			.value (req.value),
			.left  (left_w),
			.right (right_w),
			.entry (entry_w[i]),
			.tap   (tap_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// The length field shows the count modulo 256.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q   <= data_nxt;
			status_q <= status_nxt;
			length_q <= LEN_W'(count_nxt);
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.data   = data_q;
	assign rsp.status = status_q;
	assign rsp.length = length_q;

endmodule

>>> design/pal_checker.sv
// Port-level checker for the positional array list, bound to the top level.
module pal_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	input  logic                               req_ready,
	input  logic [pal_pkg::FUNC_W-1:0]         req_func,
	input  logic                               rsp_valid,
	input  logic                               rsp_ready,
	input  logic signed [pal_pkg::WORD_W-1:0]  rsp_data,
	input  logic [pal_pkg::STATUS_W-1:0]       rsp_status,
	input  logic [pal_pkg::LEN_W-1:0]          rsp_length
);
	import pal_pkg::*;

	logic req_acc;
	logic clr_acc;

	assign req_acc = req_valid && req_ready;
	assign clr_acc = req_acc && (req_func == OP_CLEAR);

	// A held result stays offered until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	// Every accepted request beat yields a result in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> rsp_valid)
		else $error("no result after an accepted request");

	// A clear leaves an empty list and reports success with no data.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_acc |=> (rsp_length == '0) && (rsp_status == ST_OK) && (rsp_data == '0))
		else $error("clear did not empty the list");

	// A failed operation never returns data.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> (rsp_data == '0))
		else $error("failed operation returned data");

	// An empty-list report means the length is zero.
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_length == '0))
		else $error("empty status with nonzero length");

endmodule

bind positional_array_list pal_checker u_pal_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_func   (req.func),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_data   (rsp.data),
	.rsp_status (rsp.status),
	.rsp_length (rsp.length)
);
